### src/fenwick_prefix_max_tree_unit_macros.svh
// Assertion macros shared by the prefix-max tree unit.
`ifndef FENWICK_PREFIX_MAX_TREE_UNIT_MACROS_SVH
`define FENWICK_PREFIX_MAX_TREE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPMT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpmt: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FPMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpmt: next-cycle check failed");

`endif

### src/fpmt_pkg.sv
// Package: sizes, microcode types and control store of the prefix-max tree unit.
`timescale 1ns / 1ps
package fpmt_pkg;

	localparam int TREE_SIZE = 1024;
	localparam int ADDR_W    = $clog2(TREE_SIZE);
	localparam int POS_W     = 11;
	localparam int DATA_W    = 32;
	localparam int UPC_W     = 4;

	localparam logic signed [DATA_W-1:0] SENTINEL = -32'sd1000000000;

	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CLEAR,
		ACT_ACCEPT,
		ACT_READ,
		ACT_USTEP,
		ACT_QSTEP,
		ACT_EMIT
	} act_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_CLR_MORE,
		C_NO_REQ,
		C_IS_QUERY,
		C_POS_ZERO,
		C_UNEXT_IN,
		C_QNEXT_NZ,
		C_OUT_BUSY
	} cond_t;

	// one control word: action, jump condition, jump target (else fall through)
	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  target;
	} ucode_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic clr_more;
		logic in_valid;
		logic is_query;
		logic pos_zero;
		logic unext_in;
		logic qnext_nz;
		logic out_busy;
	} stat_t;

	localparam upc_t PC_CLEAR  = 4'd0;
	localparam upc_t PC_IDLE   = 4'd1;
	localparam upc_t PC_DISP   = 4'd2;
	localparam upc_t PC_UREAD  = 4'd3;
	localparam upc_t PC_USTEP  = 4'd4;
	localparam upc_t PC_UDONE  = 4'd5;
	localparam upc_t PC_QREAD  = 4'd6;
	localparam upc_t PC_QSTEP  = 4'd7;
	localparam upc_t PC_QEMIT  = 4'd8;
	localparam upc_t PC_QDONE  = 4'd9;

	function automatic ucode_t ucode_rom(input upc_t pc);
		ucode_t w;
		case (pc)
			PC_CLEAR: w = '{ACT_CLEAR,  C_CLR_MORE, PC_CLEAR};
			PC_IDLE:  w = '{ACT_ACCEPT, C_NO_REQ,   PC_IDLE};
			PC_DISP:  w = '{ACT_NONE,   C_IS_QUERY, PC_QREAD};
			PC_UREAD: w = '{ACT_READ,   C_POS_ZERO, PC_IDLE};
			PC_USTEP: w = '{ACT_USTEP,  C_UNEXT_IN, PC_USTEP};
			PC_UDONE: w = '{ACT_NONE,   C_ALWAYS,   PC_IDLE};
			PC_QREAD: w = '{ACT_READ,   C_POS_ZERO, PC_QEMIT};
			PC_QSTEP: w = '{ACT_QSTEP,  C_QNEXT_NZ, PC_QSTEP};
			PC_QEMIT: w = '{ACT_EMIT,   C_OUT_BUSY, PC_QEMIT};
			PC_QDONE: w = '{ACT_NONE,   C_ALWAYS,   PC_IDLE};
			default:  w = '{ACT_NONE,   C_ALWAYS,   PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

### src/fpmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fpmt_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/fpmt_seq.sv
// Microcode sequencer: step counter, control store lookup, conditional jumps.
`timescale 1ns / 1ps
module fpmt_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  fpmt_pkg::stat_t stat,
	output fpmt_pkg::ucode_t ctrl
);

	fpmt_pkg::upc_t pc_q;
	fpmt_pkg::upc_t pc_d;
	logic           take;

	assign ctrl = fpmt_pkg::ucode_rom(pc_q);

	always_comb begin
		case (ctrl.cond)
			fpmt_pkg::C_ALWAYS:   take = 1'b1;
			fpmt_pkg::C_CLR_MORE: take = stat.clr_more;
			fpmt_pkg::C_NO_REQ:   take = !stat.in_valid;
			fpmt_pkg::C_IS_QUERY: take = stat.is_query;
			fpmt_pkg::C_POS_ZERO: take = stat.pos_zero;
			fpmt_pkg::C_UNEXT_IN: take = stat.unext_in;
			fpmt_pkg::C_QNEXT_NZ: take = stat.qnext_nz;
			fpmt_pkg::C_OUT_BUSY: take = stat.out_busy;
			default:              take = 1'b1;
		endcase
		pc_d = take ? ctrl.target : pc_q + fpmt_pkg::upc_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= fpmt_pkg::PC_CLEAR;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

### src/fpmt_dp.sv
// Datapath: position walker, running maximum, tree memory and result register.
`timescale 1ns / 1ps
module fpmt_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fpmt_pkg::ucode_t                     ctrl,
	input  logic [fpmt_pkg::POS_W-1:0]           lim,
	input  logic                                 op,
	input  logic [fpmt_pkg::POS_W-1:0]           position,
	input  logic signed [fpmt_pkg::DATA_W-1:0]   value,
	input  logic                                 in_valid,
	input  logic                                 out_stall,
	output fpmt_pkg::stat_t                      stat,
	output logic                                 in_stall,
	output logic                                 out_valid,
	output logic signed [fpmt_pkg::DATA_W-1:0]   prefix_max
);

	localparam int AW = fpmt_pkg::ADDR_W;
	localparam int PW = fpmt_pkg::POS_W;
	localparam int DW = fpmt_pkg::DATA_W;

	logic                 op_q;
	logic [PW-1:0]        pos_q;
	logic signed [DW-1:0] val_q;
	logic signed [DW-1:0] best_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        clr_q;
	logic                 out_valid_q;
	logic signed [DW-1:0] prefix_max_q;

	logic [PW-1:0]        low_bit;
	logic [PW:0]          up_nxt;
	logic [PW:0]          up_m1;
	logic [PW-1:0]        dn_nxt;
	logic [PW-1:0]        dn_m1;
	logic [PW-1:0]        cur_m1;
	logic [PW-1:0]        pos_clamp;
	logic                 accept;
	logic                 emit_go;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic signed [DW-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic signed [DW-1:0] rdata;

	// lowest set bit and the two walk directions
	assign low_bit   = pos_q & (~pos_q + PW'(1));
	assign up_nxt    = {1'b0, pos_q} + {1'b0, low_bit};
	assign up_m1     = up_nxt - (PW + 1)'(1);
	assign dn_nxt    = pos_q - low_bit;
	assign dn_m1     = dn_nxt - PW'(1);
	assign cur_m1    = pos_q - PW'(1);
	assign pos_clamp = (position > lim) ? lim : position;

	assign in_stall = (ctrl.act != fpmt_pkg::ACT_ACCEPT);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		stat.clr_more = (clr_q != {AW{1'b1}});
		stat.in_valid = in_valid;
		stat.is_query = op_q;
		stat.pos_zero = (pos_q == '0);
		stat.unext_in = (up_nxt <= {1'b0, lim});
		stat.qnext_nz = (dn_nxt != '0);
		stat.out_busy = out_valid_q && out_stall;
	end

	assign emit_go = (ctrl.act == fpmt_pkg::ACT_EMIT) && !stat.out_busy;

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = val_q;
		raddr = '0;
		case (ctrl.act)
			fpmt_pkg::ACT_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = fpmt_pkg::SENTINEL;
			end
			fpmt_pkg::ACT_READ: begin
				raddr = cur_m1[AW-1:0];
			end
			fpmt_pkg::ACT_USTEP: begin
				we    = (rdata < val_q);
				raddr = up_m1[AW-1:0];
			end
			fpmt_pkg::ACT_QSTEP: begin
				raddr = dn_m1[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	fpmt_ram #(
		.DEPTH(fpmt_pkg::TREE_SIZE),
		.WIDTH(DW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			pos_q  <= pos_clamp;
			val_q  <= value;
			best_q <= fpmt_pkg::SENTINEL;
		end
		case (ctrl.act)
			fpmt_pkg::ACT_READ: begin
				addr_q <= cur_m1[AW-1:0];
			end
			fpmt_pkg::ACT_USTEP: begin
				pos_q  <= up_nxt[PW-1:0];
				addr_q <= up_m1[AW-1:0];
			end
			fpmt_pkg::ACT_QSTEP: begin
				pos_q  <= dn_nxt;
				best_q <= (rdata > best_q) ? rdata : best_q;
			end
			default: begin
			end
		endcase
		if (emit_go) begin
			prefix_max_q <= best_q;
		end
	end

	// clear sweep counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.act == fpmt_pkg::ACT_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign prefix_max = prefix_max_q;

endmodule

### src/fenwick_prefix_max_tree_unit.sv
// Top level of the prefix-maximum Fenwick tree unit.
// Reset: async active low, then a clearing sweep writes the sentinel into all 1024
//   entries, one per cycle, with in_stall high (size writes still taken).
// Update: walks up the tree from the clamped position, visiting up to 11 entries
//   for 1024 entries; position zero visits none. One tree entry per cycle.
// Query: walks down one entry per set bit of the clamped position, then registers the
//   result; the next request waits while the result is stalled.
`timescale 1ns / 1ps
`include "fenwick_prefix_max_tree_unit_macros.svh"
module fenwick_prefix_max_tree_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [fpmt_pkg::POS_W-1:0]          position,
	input  logic signed [fpmt_pkg::DATA_W-1:0]  value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [fpmt_pkg::DATA_W-1:0]  prefix_max,
	// size register write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fpmt_pkg::POS_W-1:0]          cfg_data
);

	fpmt_pkg::ucode_t               ctrl;
	fpmt_pkg::stat_t                stat;
	logic [fpmt_pkg::POS_W-1:0]     size_q;
	logic [fpmt_pkg::POS_W-1:0]     lim;

	// size register is always writable; the host must write it only while idle, which the unit leaves unenforced
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= fpmt_pkg::POS_W'(fpmt_pkg::TREE_SIZE);
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// effective size: register clamped to the tree depth
	assign lim = (size_q > fpmt_pkg::POS_W'(fpmt_pkg::TREE_SIZE)) ?
		fpmt_pkg::POS_W'(fpmt_pkg::TREE_SIZE) : size_q;

	fpmt_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	fpmt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.lim       (lim),
		.op        (op),
		.position  (position),
		.value     (value),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.prefix_max(prefix_max)
	);

	// no request may be taken during the clearing sweep
	`FPMT_ASSERT_NOW(a_clear_blocks_req, ctrl.act == fpmt_pkg::ACT_CLEAR, in_stall)
	// an accepted request always leaves the unit busy on the next cycle
	`FPMT_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
	// a new result appears only from the emit step
	`FPMT_ASSERT_NOW(a_result_from_emit, $rose(out_valid), $past(ctrl.act == fpmt_pkg::ACT_EMIT))

endmodule
